FILE: rtl/ogu_pkg.sv
// Package for the occupancy grid update block: grid sizes, field widths, item and
// configuration structs, and the constant tables of the ray engine. No dependencies.
package ogu_pkg;

    localparam int GRID_X = 64;
    localparam int GRID_Y = 64;
    localparam int CELLS  = GRID_X * GRID_Y;
    localparam int ADDR_W = $clog2(CELLS);

    // Configuration port.
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_RESOLUTION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEAM_ANGLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OCC_STEP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FREE_STEP  = 3'd5;

    // Datapath widths of the ray engine.
    localparam int Q_W   = 20;   // signed cell quotient
    localparam int REM_W = 43;   // signed remainder in Q30 millimetres
    localparam int CS_W  = 32;   // Q2.30 cosine and sine
    localparam int Z_W   = 18;   // CORDIC residual angle
    localparam int R_W   = 18;   // distance along a ray
    localparam int CORDIC_STEPS = 16;
    localparam logic signed [CS_W-1:0] CORDIC_GAIN = 32'sd652032875;

    // Ray offset in angle units is round(h * 65536 / 720) for h half degrees.
    // Computed as ((h * 4096 + 22) * OFF_RECIP) >> OFF_SHIFT, exact for h < 128.
    localparam logic [19:0] OFF_RECIP = 20'd745655;
    localparam int OFF_SHIFT = 25;

    // Queue between the front and the back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        K_READ,
        K_SKIP,
        K_UPDATE
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] rx;
        logic [15:0] ry;
        logic [15:0] head;
        logic [15:0] range;
        logic [5:0]  cx;
        logic [5:0]  cy;
    } t_item;

    typedef struct packed {
        logic [9:0]         res;
        logic [6:0]         beam;
        logic [15:0]        min_range;
        logic [15:0]        max_range;
        logic signed [15:0] occ_step;
        logic signed [15:0] free_step;
    } t_cfg;

    // Arctangent of 2^-i in binary angle units.
    function automatic logic [13:0] atan_units(input logic [3:0] i);
        logic [13:0] v;
        unique case (i)
            4'd0:    v = 14'd8192;
            4'd1:    v = 14'd4836;
            4'd2:    v = 14'd2555;
            4'd3:    v = 14'd1297;
            4'd4:    v = 14'd651;
            4'd5:    v = 14'd326;
            4'd6:    v = 14'd163;
            4'd7:    v = 14'd81;
            4'd8:    v = 14'd41;
            4'd9:    v = 14'd20;
            4'd10:   v = 14'd10;
            4'd11:   v = 14'd5;
            4'd12:   v = 14'd3;
            4'd13:   v = 14'd1;
            4'd14:   v = 14'd1;
            default: v = 14'd0;
        endcase
        return v;
    endfunction

    // Flat store address of a cell, x major.
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [10:0] gx,
                                                    input logic [10:0] gy);
        return ADDR_W'(gx) * ADDR_W'(GRID_Y) + ADDR_W'(gy);
    endfunction

endpackage

FILE: rtl/ultrasonic_occupancy_grid_update.sv
// Top level of the ultrasonic log-odds occupancy grid update block.
// Depends on ogu_pkg, ogu_front, ogu_queue, ogu_back and ogu_ram.
//
// Usage:
// Items enter on the input channel (i_in_valid, o_in_stall). An item with
// i_op set reads one grid cell; otherwise it is a range reading that casts
// beam+1 rays into the grid when the range lies within the configured limits.
// Every item produces exactly one result transfer on the output channel
// (o_out_valid, i_out_stall): the cell value for a read, and the applied flag
// for an update.
// A read goes from the front register through the queue, the cell read and the
// result state to the output register. An update runs the position divider,
// then per ray the setup (offset, angle, 16 CORDIC rotations, two multiplies),
// one read-modify-write per sample along the ray, one more step for each sample
// whose position crosses into a new cell on either axis, and a step to close
// the ray. The single cell store port, one read-modify-write per sample, sets
// the pace of an update.
// After reset the store is cleared one cell per cycle, during which o_in_stall
// stays high; configuration writes are taken at any time.
// A result held by i_out_stall stays in the output register; meanwhile the
// front stage and the two-entry queue keep accepting items until they fill.
module ultrasonic_occupancy_grid_update import ogu_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_op,
    input  logic [15:0]          i_robot_x_mm,
    input  logic [15:0]          i_robot_y_mm,
    input  logic [15:0]          i_robot_heading,
    input  logic [15:0]          i_range_mm,
    input  logic [5:0]           i_cell_x,
    input  logic [5:0]           i_cell_y,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic signed [15:0]   o_cell_log_odds,
    output logic                 o_update_applied
);

    t_cfg  r_cfg;
    logic  clearing;
    logic  q_full;
    logic  q_empty;
    logic  push;
    logic  pop;
    t_item front_item;
    t_item head_item;

    // Configuration registers; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.res       <= 10'd100;
            r_cfg.beam      <= 7'd15;
            r_cfg.min_range <= 16'd20;
            r_cfg.max_range <= 16'd3000;
            r_cfg.occ_step  <= 16'sd355;
            r_cfg.free_step <= -16'sd355;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RESOLUTION: r_cfg.res       <= i_cfg_data[9:0];
                CFG_BEAM_ANGLE: r_cfg.beam      <= i_cfg_data[6:0];
                CFG_MIN_RANGE:  r_cfg.min_range <= i_cfg_data;
                CFG_MAX_RANGE:  r_cfg.max_range <= i_cfg_data;
                CFG_OCC_STEP:   r_cfg.occ_step  <= $signed(i_cfg_data);
                CFG_FREE_STEP:  r_cfg.free_step <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // Front: accepts and classifies, held off while the store is cleared.
    ogu_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_stall        (o_in_stall),
        .i_op           (i_op),
        .i_robot_x_mm   (i_robot_x_mm),
        .i_robot_y_mm   (i_robot_y_mm),
        .i_robot_heading(i_robot_heading),
        .i_range_mm     (i_range_mm),
        .i_cell_x       (i_cell_x),
        .i_cell_y       (i_cell_y),
        .i_cfg          (r_cfg),
        .i_hold         (clearing),
        .i_full         (q_full),
        .o_push         (push),
        .o_item         (front_item)
    );

    // Queue decoupling the front from the ray engine.
    ogu_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_item (front_item),
        .o_full (q_full),
        .i_pop  (pop),
        .o_item (head_item),
        .o_empty(q_empty)
    );

    // Back: cell store, reads and ray casting, with the output register.
    ogu_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_item          (head_item),
        .i_empty         (q_empty),
        .o_pop           (pop),
        .o_clearing      (clearing),
        .o_valid         (o_out_valid),
        .i_stall         (i_out_stall),
        .o_cell_log_odds (o_cell_log_odds),
        .o_update_applied(o_update_applied)
    );

endmodule

FILE: rtl/ogu_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ogu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/ogu_front.sv
// Front stage: takes input items, classifies them as read, skipped or applied update.
// Depends on ogu_pkg.
module ogu_front import ogu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [15:0] i_robot_x_mm,
    input  logic [15:0] i_robot_y_mm,
    input  logic [15:0] i_robot_heading,
    input  logic [15:0] i_range_mm,
    input  logic [5:0]  i_cell_x,
    input  logic [5:0]  i_cell_y,
    input  t_cfg        i_cfg,
    input  logic        i_hold,
    input  logic        i_full,
    output logic        o_push,
    output t_item       o_item
);

    logic  r_vld;
    t_item r_item;
    t_item n_item;
    logic  accept;

    assign o_stall = i_hold || (r_vld && i_full);
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_vld && !i_full;
    assign o_item  = r_item;

    always_comb begin
        n_item.rx    = i_robot_x_mm;
        n_item.ry    = i_robot_y_mm;
        n_item.head  = i_robot_heading;
        n_item.range = i_range_mm;
        n_item.cx    = i_cell_x;
        n_item.cy    = i_cell_y;
        if (i_op) begin
            n_item.kind = K_READ;
        end else if (i_range_mm < i_cfg.min_range || i_range_mm > i_cfg.max_range) begin
            n_item.kind = K_SKIP;
        end else begin
            n_item.kind = K_UPDATE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

FILE: rtl/ogu_queue.sv
// Short item queue between the front and the back.
// Depends on ogu_pkg.
module ogu_queue import ogu_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_empty
);

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QPTR_W + 1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

FILE: rtl/ogu_back.sv
// Back engine: clearing pass, cell reads, and the ray caster with its divider,
// CORDIC, stepping and cell read-modify-write. Depends on ogu_pkg and ogu_ram.
module ogu_back import ogu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_item              i_item,
    input  logic               i_empty,
    output logic               o_pop,
    output logic               o_clearing,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_cell_log_odds,
    output logic               o_update_applied
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RDWAIT,
        S_DIV,
        S_OFF,
        S_ANG,
        S_CORD,
        S_MULX,
        S_MULY,
        S_SAMPLE,
        S_WRITE,
        S_DONE
    } t_state;

    t_state r_state;
    logic [ADDR_W-1:0] r_clr;
    t_item  r_item;
    logic   r_rdok;

    // Divider for robot position over resolution.
    logic [15:0] r_dvx, r_dvy;
    logic [9:0]  r_rmx, r_rmy;
    logic [3:0]  r_dcnt;

    // Ray setup.
    logic [6:0]  r_k;
    logic [38:0] r_prod;
    logic        r_negoff;
    logic signed [CS_W-1:0] r_cx, r_cy, r_cs, r_sn;
    logic signed [Z_W-1:0]  r_cz;
    logic [3:0]  r_ci;
    logic [1:0]  r_quad;
    logic signed [REM_W-1:0] r_dx, r_dy;

    // Stepping along a ray.
    logic signed [Q_W-1:0]   r_qx, r_qy;
    logic signed [REM_W-1:0] r_remx, r_remy;
    logic [R_W-1:0]          r_r;
    logic                    r_hit;
    logic [ADDR_W-1:0]       r_addr;
    logic signed [15:0]      r_inc;

    // Result.
    logic signed [15:0] r_res_val;
    logic               r_res_app;
    logic               r_out_vld;
    logic signed [15:0] r_out_val;
    logic               r_out_app;

    // RAM ports.
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [15:0]        ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [15:0]        ram_rdata;

    logic [9:0]              res_eff;
    logic signed [REM_W-1:0] div_v;
    logic [R_W-1:0]          range_lim;

    // Combinational helpers.
    logic [10:0] tx, ty;
    logic        gex, gey;
    logic signed [8:0] half;
    logic [6:0]  mag;
    logic [18:0] n2;
    logic [15:0] off16, ang;
    logic [CS_W-1:0] mask;
    logic signed [CS_W-1:0] tdx, tdy, n_cx, n_cy;
    logic signed [Z_W-1:0]  n_cz;
    logic normx, normy, hitx, hity;
    logic [10:0] gx, gy;
    logic signed [20:0] two_r, lo_lim, hi_lim;
    logic signed [15:0] n_inc;
    logic signed [16:0] sum;
    logic signed [15:0] sat;
    logic rd_onmap;
    logic can_load;

    assign res_eff   = (i_cfg.res == 10'd0) ? 10'd1 : i_cfg.res;
    assign div_v     = $signed({3'b000, res_eff, 30'd0});
    assign range_lim = R_W'(r_item.range) + R_W'(res_eff);
    assign can_load  = !r_out_vld || !i_stall;

    ogu_ram #(
        .WIDTH(16),
        .DEPTH(CELLS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        // Restoring division, one quotient bit per cycle for both axes.
        tx  = {r_rmx, r_dvx[15]};
        ty  = {r_rmy, r_dvy[15]};
        gex = (tx >= {1'b0, res_eff});
        gey = (ty >= {1'b0, res_eff});

        // Ray offset in angle units from the half degree offset.
        half  = $signed({1'b0, r_k, 1'b0}) - $signed({2'b00, i_cfg.beam});
        mag   = half[8] ? 7'(-half) : half[6:0];
        n2    = {mag, 12'd0} + 19'd22;
        off16 = {2'b00, r_prod[38:OFF_SHIFT]};
        ang   = r_negoff ? (r_item.head - off16) : (r_item.head + off16);

        // One CORDIC rotation; shifts truncate toward zero.
        mask = ~({CS_W{1'b1}} << r_ci);
        tdx  = (r_cx >>> r_ci) + ((r_cx[CS_W-1] && |(r_cx & mask)) ? 32'sd1 : 32'sd0);
        tdy  = (r_cy >>> r_ci) + ((r_cy[CS_W-1] && |(r_cy & mask)) ? 32'sd1 : 32'sd0);
        if (!r_cz[Z_W-1]) begin
            n_cx = r_cx - tdy;
            n_cy = r_cy + tdx;
            n_cz = r_cz - $signed({4'b0000, atan_units(r_ci)});
        end else begin
            n_cx = r_cx + tdy;
            n_cy = r_cy - tdx;
            n_cz = r_cz + $signed({4'b0000, atan_units(r_ci)});
        end

        // Sample position as floor quotient plus remainder; the cell index
        // truncates toward zero, so a point just below zero lands in cell 0.
        normx = !r_remx[REM_W-1] && (r_remx < div_v);
        normy = !r_remy[REM_W-1] && (r_remy < div_v);
        hitx  = (!r_qx[Q_W-1] && r_qx < $signed(Q_W'(GRID_X)))
              || (r_qx == -1 && r_remx != '0);
        hity  = (!r_qy[Q_W-1] && r_qy < $signed(Q_W'(GRID_Y)))
              || (r_qy == -1 && r_remy != '0);
        gx    = r_qx[Q_W-1] ? 11'd0 : 11'(r_qx);
        gy    = r_qy[Q_W-1] ? 11'd0 : 11'(r_qy);

        // Doubled distances classify the sample.
        two_r  = $signed({2'b00, r_r, 1'b0});
        lo_lim = $signed({4'b0000, r_item.range, 1'b0}) - $signed({11'd0, res_eff});
        hi_lim = $signed({4'b0000, r_item.range, 1'b0}) + $signed({11'd0, res_eff});
        if (two_r < lo_lim) begin
            n_inc = i_cfg.free_step;
        end else if (two_r > hi_lim) begin
            n_inc = 16'sd0;
        end else begin
            n_inc = i_cfg.occ_step;
        end

        sum = $signed({ram_rdata[15], ram_rdata}) + $signed({r_inc[15], r_inc});
        if (sum[16] != sum[15]) begin
            sat = sum[16] ? 16'sh8000 : 16'sh7FFF;
        end else begin
            sat = sum[15:0];
        end

        rd_onmap = (11'(i_item.cx) < 11'(GRID_X)) && (11'(i_item.cy) < 11'(GRID_Y));

        // RAM port selection.
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = sat;
        ram_raddr = r_addr;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
            end
            S_IDLE: begin
                ram_raddr = cell_addr(11'(i_item.cx), 11'(i_item.cy));
            end
            S_SAMPLE: begin
                ram_raddr = cell_addr(gx, gy);
            end
            S_WRITE: begin
                ram_we = r_hit;
            end
            default: begin
            end
        endcase
    end

    assign o_pop            = (r_state == S_IDLE) && !i_empty;
    assign o_clearing       = (r_state == S_CLEAR);
    assign o_valid          = r_out_vld;
    assign o_cell_log_odds  = r_out_val;
    assign o_update_applied = r_out_app;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (r_state == S_DONE && can_load) begin
                r_out_vld <= 1'b1;
                r_out_val <= r_res_val;
                r_out_app <= r_res_app;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == ADDR_W'(CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (!i_empty) begin
                        r_item    <= i_item;
                        r_rdok    <= rd_onmap;
                        r_res_val <= '0;
                        r_res_app <= 1'b0;
                        r_dvx     <= i_item.rx;
                        r_dvy     <= i_item.ry;
                        r_rmx     <= '0;
                        r_rmy     <= '0;
                        r_dcnt    <= '0;
                        unique case (i_item.kind)
                            K_READ:   r_state <= S_RDWAIT;
                            K_UPDATE: r_state <= S_DIV;
                            default:  r_state <= S_DONE;
                        endcase
                    end
                end
                S_RDWAIT: begin
                    r_res_val <= r_rdok ? $signed(ram_rdata) : 16'sd0;
                    r_state   <= S_DONE;
                end
                S_DIV: begin
                    r_rmx  <= gex ? 10'(tx - {1'b0, res_eff}) : tx[9:0];
                    r_rmy  <= gey ? 10'(ty - {1'b0, res_eff}) : ty[9:0];
                    r_dvx  <= {r_dvx[14:0], gex};
                    r_dvy  <= {r_dvy[14:0], gey};
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == 4'd15) begin
                        r_k     <= '0;
                        r_state <= S_OFF;
                    end
                end
                S_OFF: begin
                    r_prod   <= 39'(n2) * 39'(OFF_RECIP);
                    r_negoff <= half[8];
                    r_state  <= S_ANG;
                end
                S_ANG: begin
                    r_cx    <= CORDIC_GAIN;
                    r_cy    <= '0;
                    r_cz    <= $signed({4'b0000, ang[13:0]});
                    r_quad  <= ang[15:14];
                    r_ci    <= '0;
                    r_state <= S_CORD;
                end
                S_CORD: begin
                    r_cx <= n_cx;
                    r_cy <= n_cy;
                    r_cz <= n_cz;
                    r_ci <= r_ci + 1'b1;
                    if (r_ci == 4'(CORDIC_STEPS - 1)) begin
                        unique case (r_quad)
                            2'd0: begin
                                r_cs <= n_cx;
                                r_sn <= n_cy;
                            end
                            2'd1: begin
                                r_cs <= -n_cy;
                                r_sn <= n_cx;
                            end
                            2'd2: begin
                                r_cs <= -n_cx;
                                r_sn <= -n_cy;
                            end
                            default: begin
                                r_cs <= n_cy;
                                r_sn <= -n_cx;
                            end
                        endcase
                        r_state <= S_MULX;
                    end
                end
                S_MULX: begin
                    r_dx    <= $signed({1'b0, res_eff}) * r_cs;
                    r_state <= S_MULY;
                end
                S_MULY: begin
                    r_dy    <= $signed({1'b0, res_eff}) * r_sn;
                    r_qx    <= $signed({4'b0000, r_dvx});
                    r_qy    <= $signed({4'b0000, r_dvy});
                    r_remx  <= $signed({3'b000, r_rmx, 30'd0});
                    r_remy  <= $signed({3'b000, r_rmy, 30'd0});
                    r_r     <= '0;
                    r_state <= S_SAMPLE;
                end
                S_SAMPLE: begin
                    if (!normx || !normy) begin
                        // Bring each remainder back into [0, div) one step at a time.
                        if (r_remx[REM_W-1]) begin
                            r_remx <= r_remx + div_v;
                            r_qx   <= r_qx - 1'b1;
                        end else if (!normx) begin
                            r_remx <= r_remx - div_v;
                            r_qx   <= r_qx + 1'b1;
                        end
                        if (r_remy[REM_W-1]) begin
                            r_remy <= r_remy + div_v;
                            r_qy   <= r_qy - 1'b1;
                        end else if (!normy) begin
                            r_remy <= r_remy - div_v;
                            r_qy   <= r_qy + 1'b1;
                        end
                    end else if (r_r > range_lim) begin
                        if (r_k == i_cfg.beam) begin
                            r_res_app <= 1'b1;
                            r_state   <= S_DONE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_OFF;
                        end
                    end else begin
                        r_hit   <= hitx && hity;
                        r_addr  <= cell_addr(gx, gy);
                        r_inc   <= n_inc;
                        r_remx  <= r_remx + r_dx;
                        r_remy  <= r_remy + r_dy;
                        r_r     <= r_r + R_W'(res_eff);
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_state <= S_SAMPLE;
                end
                S_DONE: begin
                    if (can_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
